/* hw/rtl/kbs_pkg.sv */
// Package for the kinematic bicycle step unit: field types, constants and the CORDIC angle table.
package kbs_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 24;
    localparam int TIME_BITS      = 16;
    localparam int TRIG_STEPS     = 24;
    localparam logic [31:0] TRIG_GAIN = 32'h26DD3B6A;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam int CFG_ADDR_BITS  = 3;

    localparam logic [CFG_ADDR_BITS-1:0] ADDR_WHEELBASE = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_REVERSE   = 3'd4;

    typedef struct packed {
        logic [15:0]        delta_time;
        logic               has_command;
        logic signed [23:0] accel_cmd;
        logic signed [15:0] steer_cmd;
    } kbs_in_t;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [15:0] yaw_change;
        logic signed [23:0] speed;
        logic [15:0]        heading_now;
    } kbs_out_t;

    function automatic logic [31:0] turn_angle(input logic [4:0] i);
        unique case (i)
            5'd0:  return 32'h20000000;
            5'd1:  return 32'h12E4051E;
            5'd2:  return 32'h09FB385B;
            5'd3:  return 32'h051111D4;
            5'd4:  return 32'h028B0D43;
            5'd5:  return 32'h0145D7E1;
            5'd6:  return 32'h00A2F61E;
            5'd7:  return 32'h00517C55;
            5'd8:  return 32'h0028BE53;
            5'd9:  return 32'h00145F2F;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2FA;
            5'd15: return 32'h0000517D;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A30;
            5'd19: return 32'h00000518;
            5'd20: return 32'h0000028C;
            5'd21: return 32'h00000146;
            5'd22: return 32'h000000A3;
            5'd23: return 32'h00000051;
            default: return 32'h0;
        endcase
    endfunction

endpackage

/* hw/rtl/kinematic_bicycle_step_unit.sv */
// Kinematic bicycle step unit: one simulation tick per input transfer.
//
// Usage: drive in_valid with an in_data tick (time step, optional command);
// the block answers with exactly one out_data transfer per tick holding the
// position offsets, yaw change, updated speed and heading. Wheelbase and
// reverse enable are to be written over the APB port by the user only while
// the block is idle; the block itself does not enforce it. A tick runs as a
// sequence of bit-serial steps: two multiplies for speed and distance with a
// speed update between them, two CORDIC runs (load, 24 iterations, read out)
// sharing one rotator, two shift-add multiplies for the offsets, a multiply
// and a restoring divider for the yaw ratio and a multiply for the angle
// scale. A new tick is not taken until the result of the last one has been
// transferred; the next tick is taken the cycle after the result transfer.
// While the receiver holds out_stall the result is held and in_stall stays
// high. Reset clears the velocity, steering and heading state and loads
// wheelbase 1.0 and reverse disabled.
module kinematic_bicycle_step_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  kbs_pkg::kbs_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output kbs_pkg::kbs_out_t                    out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kbs_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import kbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DV, S_VEL, S_VDT, S_TRIG, S_OFS, S_DIV, S_YAW, S_DONE
    } state_t;

    localparam int ACC_W = 64;

    state_t            state_reg;
    logic [23:0]       wheelbase_reg;
    logic              reverse_reg;
    logic signed [23:0] velocity_reg;
    logic [15:0]       steer_reg;
    logic [15:0]       heading_reg;
    logic [15:0]       dt_reg;

    // shared shift-add multiplier: acc += mcand when mplier lsb, mplier shifts
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  mcand_reg;
    logic [31:0]       mplier_reg;
    logic [5:0]        cnt_reg;
    logic              neg_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic               pass_reg;   // 0: steer+heading, 1: steer
    logic signed [16:0] cb_reg, sb_reg, ss_reg;
    logic [1:0]         ofs_reg;    // offset phase sub-step
    logic signed [23:0] vdt_reg;
    logic signed [23:0] ox_reg, oy_reg;
    logic signed [15:0] yaw_reg;
    // divider
    logic [39:0]       rem_reg;
    logic [39:0]       quo_reg;
    logic [32:0]       r_reg;

    assign pready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_WHEELBASE: prdata = {8'd0, wheelbase_reg};
            ADDR_REVERSE:   prdata = {31'd0, reverse_reg};
            default:        prdata = '0;
        endcase
    end

    function automatic logic [63:0] rnd_shift(input logic [63:0] p, input int s);
        logic [63:0] t;
        t = p + (64'd1 << (s - 1));
        return t >> s;
    endfunction

    function automatic logic signed [23:0] sat24(input logic neg, input logic [63:0] m);
        if (!neg)
            return (m > 64'd8388607) ? 24'sh7FFFFF : m[23:0];
        else
            return (m > 64'd8388608) ? 24'sh800000 : 24'(-$signed({1'b0, m[23:0]}));
    endfunction

    function automatic logic [23:0] magn24(input logic signed [23:0] x);
        return x[23] ? 24'(-x) : x;
    endfunction

    function automatic logic signed [16:0] trig_out(input logic signed [33:0] v);
        logic [33:0] m;
        logic [33:0] q;
        m = v[33] ? 34'(-v) : 34'(v);
        q = (m + 34'd16384) >> 15;
        if (q > 34'd32768)
            q = 34'd32768;
        return v[33] ? -$signed({1'b0, q[15:0]}) : $signed({1'b0, q[15:0]});
    endfunction

    // CORDIC step terms, angle input and divider operands
    logic signed [33:0] xs, ys;
    logic [31:0]        tab;
    logic [31:0]        a_full;
    logic [39:0]        den;
    logic [39:0]        rem_sh;
    always_comb
    begin
        xs  = cx_reg >>> cnt_reg[4:0];
        ys  = cy_reg >>> cnt_reg[4:0];
        tab = turn_angle(cnt_reg[4:0]);
        a_full = {(pass_reg ? steer_reg : 16'(steer_reg + heading_reg)), 16'd0};
        den = (wheelbase_reg == 24'd0) ? 40'd1 : {16'd0, wheelbase_reg};
        rem_sh = {rem_reg[38:0], quo_reg[39]};
    end

    logic signed [24:0] vsum;
    logic [23:0]        dvm;
    logic signed [24:0] dvs;
    logic [23:0]        yaw_mag;

    // speed update and yaw magnitude
    always_comb
    begin
        dvm = 24'(rnd_shift(acc_reg, 16));
        dvs = neg_reg ? -$signed({1'b0, dvm}) : $signed({1'b0, dvm});
        if (velocity_reg > 0 && dvs < -25'(velocity_reg))
            dvs = -25'(velocity_reg);
        vsum = 25'(velocity_reg) + dvs;
        if (vsum > 25'sd8388607)
            vsum = 25'sd8388607;
        else if (vsum < -25'sd8388608)
            vsum = -25'sd8388608;
        if (!reverse_reg && vsum < 0)
            vsum = '0;
        yaw_mag = 24'(rnd_shift(r_reg[32] ? {INV_TWO_PI_Q32, 32'd0} : acc_reg, 31));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wheelbase_reg <= 24'd256;
            reverse_reg   <= 1'b0;
            velocity_reg  <= '0;
            steer_reg     <= '0;
            heading_reg   <= '0;
            out_valid     <= 1'b0;
            dt_reg        <= '0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            flip_reg      <= 1'b0;
            pass_reg      <= 1'b0;
            cb_reg        <= '0;
            sb_reg        <= '0;
            ss_reg        <= '0;
            ofs_reg       <= '0;
            vdt_reg       <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            yaw_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            r_reg         <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr == ADDR_WHEELBASE)
                    wheelbase_reg <= pwdata[23:0];
                else if (paddr == ADDR_REVERSE)
                    reverse_reg <= pwdata[0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dt_reg    <= in_data.delta_time;
                        if (in_data.has_command)
                            steer_reg <= in_data.steer_cmd;
                        acc_reg    <= '0;
                        mcand_reg  <= {40'd0, magn24(in_data.has_command ?
                                        in_data.accel_cmd : 24'sd0)};
                        mplier_reg <= {16'd0, in_data.delta_time};
                        neg_reg    <= in_data.has_command & in_data.accel_cmd[23];
                        cnt_reg    <= '0;
                        state_reg  <= S_DV;
                    end
                end
                S_DV, S_VDT:
                begin
                    // one multiplier bit per cycle
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                        state_reg <= (state_reg == S_DV) ? S_VEL : S_TRIG;
                    if (cnt_reg == 6'd16 - 6'd1 && state_reg == S_VDT)
                    begin
                        cnt_reg <= '0;
                        pass_reg <= 1'b0;
                        flip_reg <= 1'b0;
                        cx_reg <= 34'sd0;
                    end
                end
                S_VEL:
                begin
                    velocity_reg <= vsum[23:0];
                    acc_reg    <= '0;
                    mcand_reg  <= {40'd0, magn24(vsum[23:0])};
                    mplier_reg <= {16'd0, dt_reg};
                    neg_reg    <= vsum[24];
                    cnt_reg    <= '0;
                    state_reg  <= S_VDT;
                end
                S_TRIG:
                begin
                    if (cx_reg == 34'sd0 && cnt_reg == 6'd0)
                    begin
                        // load with quadrant fold
                        flip_reg <= (a_full[31:30] == 2'd1) || (a_full[31:30] == 2'd2);
                        cx_reg <= $signed({2'b00, TRIG_GAIN});
                        cy_reg <= '0;
                        cz_reg <= $signed({{2{a_full[31] ^ ((a_full[31:30] == 2'd1) ||
                                  (a_full[31:30] == 2'd2))}},
                                  a_full[31] ^ ((a_full[31:30] == 2'd1) ||
                                  (a_full[31:30] == 2'd2)), a_full[30:0]});
                        if (pass_reg == 1'b0)
                            vdt_reg <= sat24(neg_reg, rnd_shift(acc_reg, 16));
                    end
                    else
                    begin
                        if (cz_reg >= 0)
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - $signed({2'b00, tab});
                        end
                        else
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + $signed({2'b00, tab});
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd23)
                        begin
                            cnt_reg <= 6'd32;
                        end
                    end
                    if (cnt_reg == 6'd32)
                    begin
                        if (!pass_reg)
                        begin
                            cb_reg <= trig_out(flip_reg ? -cx_reg : cx_reg);
                            sb_reg <= trig_out(flip_reg ? -cy_reg : cy_reg);
                            pass_reg <= 1'b1;
                            cnt_reg <= '0;
                            cx_reg <= 34'sd0;
                        end
                        else
                        begin
                            ss_reg <= trig_out(flip_reg ? -cy_reg : cy_reg);
                            ofs_reg <= 2'd0;
                            cnt_reg <= '0;
                            state_reg <= S_OFS;
                        end
                    end
                end
                S_OFS:
                begin
                    // phase 0/2 load, phase 1/3 run the shift-add multiply by the trig factor
                    unique case (ofs_reg)
                        2'd0, 2'd2:
                        begin
                            acc_reg    <= '0;
                            mcand_reg  <= {40'd0, magn24(vdt_reg)};
                            mplier_reg <= (ofs_reg == 2'd0) ?
                                32'(cb_reg[16] ? -cb_reg : cb_reg) :
                                32'(sb_reg[16] ? -sb_reg : sb_reg);
                            neg_reg <= vdt_reg[23] ^ ((ofs_reg == 2'd0) ? cb_reg[16]
                                                                        : sb_reg[16]);
                            cnt_reg <= '0;
                            ofs_reg <= ofs_reg + 2'd1;
                        end
                        default:
                        begin
                            if (mplier_reg[0])
                                acc_reg <= acc_reg + mcand_reg;
                            mcand_reg  <= mcand_reg << 1;
                            mplier_reg <= mplier_reg >> 1;
                            cnt_reg    <= cnt_reg + 6'd1;
                            if (cnt_reg == 6'd18)
                            begin
                                if (ofs_reg == 2'd1)
                                begin
                                    ox_reg  <= sat24(neg_reg, rnd_shift(acc_reg, 15));
                                    ofs_reg <= 2'd2;
                                end
                                else
                                begin
                                    oy_reg <= sat24(neg_reg, rnd_shift(acc_reg, 15));
                                    // numerator for the yaw ratio
                                    acc_reg    <= '0;
                                    mcand_reg  <= {40'd0, magn24(vdt_reg)};
                                    mplier_reg <= 32'(ss_reg[16] ? -ss_reg : ss_reg);
                                    neg_reg    <= vdt_reg[23] ^ ss_reg[16];
                                    cnt_reg    <= '0;
                                    ofs_reg    <= 2'd0;
                                    state_reg  <= S_DIV;
                                end
                            end
                        end
                    endcase
                end
                S_DIV:
                begin
                    // multiply, then restoring divide one quotient bit a cycle
                    if (ofs_reg == 2'd0)
                    begin
                        if (mplier_reg[0])
                            acc_reg <= acc_reg + mcand_reg;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd18)
                        begin
                            ofs_reg <= 2'd1;
                            quo_reg <= 40'(acc_reg + {25'd0, den[39:1]});
                            rem_reg <= '0;
                            cnt_reg <= '0;
                        end
                    end
                    else
                    begin
                        if (rem_sh >= den)
                        begin
                            rem_reg <= rem_sh - den;
                            quo_reg <= {quo_reg[38:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[38:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd39)
                        begin
                            cnt_reg   <= '0;
                            ofs_reg   <= 2'd0;
                            state_reg <= S_YAW;
                        end
                    end
                end
                S_YAW:
                begin
                    if (ofs_reg == 2'd0)
                    begin
                        r_reg      <= (quo_reg > 40'h100000000) ? 33'h100000000
                                                                 : quo_reg[32:0];
                        acc_reg    <= '0;
                        mcand_reg  <= {32'd0, INV_TWO_PI_Q32};
                        mplier_reg <= (quo_reg > 40'h100000000) ? 32'd0 : quo_reg[31:0];
                        ofs_reg    <= 2'd1;
                        cnt_reg    <= '0;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                            acc_reg <= acc_reg + mcand_reg;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd32)
                        begin
                            yaw_reg <= neg_reg ? 16'(-yaw_mag) : yaw_mag[15:0];
                            heading_reg <= heading_reg +
                                           (neg_reg ? 16'(-yaw_mag) : yaw_mag[15:0]);
                            out_valid <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_data.offset_x    = ox_reg;
    assign out_data.offset_y    = oy_reg;
    assign out_data.yaw_change  = yaw_reg;
    assign out_data.speed       = velocity_reg;
    assign out_data.heading_now = heading_reg;

endmodule

/* test/kinematic_bicycle_step_unit_test.sv */
// Testbench for the kinematic bicycle step unit: directed and random ticks checked against a predictor.
module kinematic_bicycle_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kbs_pkg::*;

    localparam longint SPEED_MAX = 64'sd8388607;
    localparam longint SPEED_MIN = -64'sd8388608;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint INV_TURN_Q32 = 64'sd683565276;
    localparam longint RATIO_CAP = 64'sd4294967296;
    localparam int HOLD_CYCLES = 800;

    localparam longint ROT_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    localparam int DIR_ROWS = 16;
    localparam kbs_in_t DIR_TICKS [DIR_ROWS] = '{
        '{16'h0000, 1'b0, 24'sh000000, 16'sh0000},
        '{16'hFFFF, 1'b1, 24'sh800000, 16'sh7FFF},
        '{16'hFFFF, 1'b1, 24'sh7FFFFF, 16'sh8000},
        '{16'hFFFF, 1'b0, 24'shA5A5A5, 16'sh5A5A},
        '{16'h0001, 1'b1, 24'sh000001, 16'sh4000},
        '{16'h8000, 1'b1, 24'shFFFFFF, 16'shC000},
        '{16'hFFFF, 1'b1, 24'sh800000, 16'sh2000},
        '{16'h4000, 1'b1, 24'sh010000, 16'sh0000},
        '{16'hFFFF, 1'b0, 24'sh000000, 16'sh0000},
        '{16'h2000, 1'b1, 24'sh000100, 16'shE000},
        '{16'hFFFF, 1'b1, 24'sh7FFFFF, 16'sh7FFF},
        '{16'hFFFF, 1'b0, 24'sh7FFFFF, 16'sh8000},
        '{16'h0000, 1'b1, 24'sh7FFFFF, 16'sh1234},
        '{16'hC000, 1'b1, 24'shFF0000, 16'sh0001},
        '{16'hFFFF, 1'b1, 24'sh800000, 16'shFFFF},
        '{16'h1000, 1'b0, 24'sh000000, 16'sh0000}
    };
    // rows whose result is known by inspection: a stopped vehicle yields all zeros
    localparam logic [DIR_ROWS-1:0] DIR_ZERO = 16'b0000_0000_0000_0011;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    kbs_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    kbs_out_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kinematic_bicycle_step_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // vehicle state as the predictor sees it
    longint veh_speed;
    logic [15:0] veh_steer;
    logic [15:0] veh_heading;
    logic [23:0] wheelbase_reg;
    logic reverse_reg;

    kbs_out_t tick_results_q [$];
    int fault_count = 0;
    bit idling_on = 1'b1;
    bit hold_request = 1'b0;

    function automatic longint unsigned mag(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint mul_rnd(longint a, longint b, int s);
        longint unsigned p;
        p = mag(a) * mag(b);
        if (s > 0)
            p = (p + (64'd1 << (s - 1))) >> s;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    task automatic cordic_trig(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] a;
        bit flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        a = {ang, 16'h0000};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a + 32'h80000000;
        z = longint'($signed(a));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - ROT_STEP[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + ROT_STEP[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clip(mul_rnd(x, 1, 15), -32768, 32768);
        s = clip(mul_rnd(y, 1, 15), -32768, 32768);
    endtask

    task automatic advance_vehicle(input kbs_in_t t, output kbs_out_t r);
        longint accel;
        longint dv;
        longint vdt;
        longint cb;
        longint sb;
        longint cs;
        longint ss;
        longint ratio;
        longint yaw;
        longint unsigned num;
        longint unsigned den;
        accel = 0;
        if (t.has_command)
        begin
            accel = longint'(t.accel_cmd);
            veh_steer = t.steer_cmd;
        end
        dv = mul_rnd(accel, longint'(t.delta_time), 16);
        if (veh_speed > 0 && dv < -veh_speed)
            dv = -veh_speed;
        veh_speed = clip(veh_speed + dv, SPEED_MIN, SPEED_MAX);
        if (!reverse_reg && veh_speed < 0)
            veh_speed = 0;
        vdt = mul_rnd(veh_speed, longint'(t.delta_time), 16);
        cordic_trig(veh_steer + veh_heading, cb, sb);
        cordic_trig(veh_steer, cs, ss);
        den = (wheelbase_reg == 0) ? 1 : longint'(wheelbase_reg);
        num = mag(vdt) * mag(ss);
        num = (num + den / 2) / den;
        if (num > RATIO_CAP)
            num = RATIO_CAP;
        ratio = ((vdt < 0) != (ss < 0)) ? -longint'(num) : longint'(num);
        yaw = mul_rnd(ratio, INV_TURN_Q32, 31);
        veh_heading = veh_heading + yaw[15:0];
        r.offset_x = 24'(clip(mul_rnd(vdt, cb, 15), SPEED_MIN, SPEED_MAX));
        r.offset_y = 24'(clip(mul_rnd(vdt, sb, 15), SPEED_MIN, SPEED_MAX));
        r.yaw_change = yaw[15:0];
        r.speed = veh_speed[23:0];
        r.heading_now = veh_heading;
    endtask

    task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WHEELBASE)
            wheelbase_reg = value[23:0];
        else
            reverse_reg = value[0];
    endtask

    task automatic send_tick(input kbs_in_t t, input bit zero_known);
        kbs_out_t want;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_data <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        advance_vehicle(t, want);
        if (zero_known)
            want = '0;
        tick_results_q.push_back(want);
    endtask

    function automatic kbs_in_t random_tick();
        kbs_in_t t;
        t.delta_time = 16'($urandom());
        t.has_command = ($urandom_range(0, 9) < 7);
        t.steer_cmd = 16'($urandom());
        case ($urandom_range(0, 9))
            0, 1: t.accel_cmd = 24'($urandom());
            2: t.accel_cmd = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            3: t.accel_cmd = '0;
            default: t.accel_cmd = 24'($signed($urandom_range(0, 8191)) - 4096) <<< 4;
        endcase
        if ($urandom_range(0, 7) == 0)
            t.delta_time = 16'($urandom_range(0, 3));
        return t;
    endfunction

    // drain the block before touching configuration
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic run_phase(input logic [23:0] wb, input bit rev, input int n, input bit hold);
        wait_idle();
        apb_write(ADDR_WHEELBASE, {8'h00, wb});
        apb_write(ADDR_REVERSE, {31'd0, rev});
        for (int i = 0; i < n; i++)
        begin
            if (hold && i == n / 2)
                hold_request = 1'b1;
            send_tick(random_tick(), 1'b0);
        end
    endtask

    // receiver: stall in bursts, take one long hold on request
    initial
    begin
        int burst;
        int hold_left;
        bit stall_next;
        kbs_out_t want;
        burst = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (tick_results_q.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected transfer: %p", out_data);
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    if (want !== out_data)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch x %0d/%0d y %0d/%0d yaw %0d/%0d spd %0d/%0d hd %0d/%0d",
                                want.offset_x, out_data.offset_x,
                                want.offset_y, out_data.offset_y,
                                want.yaw_change, out_data.yaw_change,
                                want.speed, out_data.speed,
                                want.heading_now, out_data.heading_now);
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            stall_next = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                stall_next = 1'b1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 6);
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    initial
    begin
        veh_speed = 0;
        veh_steer = '0;
        veh_heading = '0;
        wheelbase_reg = 24'd256;
        reverse_reg = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
            send_tick(DIR_TICKS[i], DIR_ZERO[i]);
        run_phase(24'd1, 1'b1, 250, 1'b0);
        run_phase(24'hFFFFFF, 1'b0, 200, 1'b0);
        run_phase(24'd0, 1'b1, 200, 1'b0);
        run_phase(24'd256, 1'b0, 200, 1'b0);
        run_phase(24'($urandom_range(1, 4096)), 1'b1, 300, 1'b1);
        idling_on = 1'b0;
        run_phase(24'($urandom_range(1, 1024)), 1'b0, 300, 1'b0);
        wait_idle();
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // leftover expectations show up as a hang and end here
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
